>>> rtl/utf8_to_cp866_transcoder_unit_defines.svh
// Assertion macros for the UTF-8 to CP866 transcoder.
// Depends on nothing; the asserting file provides clk_i and rst_ni.
`ifndef UTF8_TO_CP866_TRANSCODER_UNIT_DEFINES_SVH
`define UTF8_TO_CP866_TRANSCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define U8CP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("transcoder check failed");
// The consequent must hold in the cycle after the antecedent.
`define U8CP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("transcoder check failed");
`else
`define U8CP_ASSERT_SAME(lbl, ante, cons)
`define U8CP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/u8cp_pkg.sv
// Shared types, constants and the code point to CP866 map function.
// Used by every module of the UTF-8 to CP866 transcoder; depends on nothing.
package u8cp_pkg;

  localparam int CpW       = 21;
  localparam int CountW    = 16;
  localparam int MaxW      = 16;
  localparam int FifoDepth = 2;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int FillW     = $clog2(FifoDepth + 1);

  localparam logic ResChar = 1'b0;
  localparam logic ResEnd  = 1'b1;

  localparam logic [7:0] Unmapped = 8'h3F;

  typedef enum logic [1:0] {
    EvNone = 2'b00,
    EvChar = 2'b01,
    EvEnd  = 2'b10
  } evt_kind_e;

  typedef enum logic [1:0] {
    PhA = 2'b01,
    PhB = 2'b10
  } phase_e;

  // One queue entry holds everything one input byte causes: an optional
  // character from a finished or cut-short sequence, then an optional
  // character or end marker coming from the byte itself.
  typedef struct packed {
    logic             a_valid;
    logic [CpW-1:0]   a_cp;
    evt_kind_e        b_kind;
    logic [7:0]       b_byte;
  } evt_entry_t;

  function automatic logic [7:0] map_code(input logic [CpW-1:0] v);
    logic [7:0] r;
    r = Unmapped;
    if (v < CpW'(21'h80)) begin
      r = v[7:0];
    end else if (v >= CpW'(21'h410) && v <= CpW'(21'h42F)) begin
      r = 8'h80 + {2'b00, v[5:0] - 6'h10};
    end else if (v >= CpW'(21'h430) && v <= CpW'(21'h43F)) begin
      r = 8'hA0 + {4'b0000, v[3:0]};
    end else if (v >= CpW'(21'h440) && v <= CpW'(21'h44F)) begin
      r = 8'hE0 + {4'b0000, v[3:0]};
    end else begin
      unique case (v)
        21'h000401: r = 8'hF0;
        21'h000451: r = 8'hF1;
        21'h002116: r = 8'hFC;
        21'h0000B0: r = 8'hF8;
        21'h0000B7: r = 8'hFA;
        21'h002591: r = 8'hB0;
        21'h002592: r = 8'hB1;
        21'h002593: r = 8'hB2;
        21'h002502: r = 8'hB3;
        21'h002524: r = 8'hB4;
        21'h002563: r = 8'hB9;
        21'h002551: r = 8'hBA;
        21'h002557: r = 8'hBB;
        21'h00255D: r = 8'hBC;
        21'h002510: r = 8'hBF;
        21'h002514: r = 8'hC0;
        21'h002534: r = 8'hC1;
        21'h00252C: r = 8'hC2;
        21'h00251C: r = 8'hC3;
        21'h002500: r = 8'hC4;
        21'h00253C: r = 8'hC5;
        21'h00255A: r = 8'hC8;
        21'h002554: r = 8'hC9;
        21'h002569: r = 8'hCA;
        21'h002566: r = 8'hCB;
        21'h002560: r = 8'hCC;
        21'h002550: r = 8'hCD;
        21'h00256C: r = 8'hCE;
        21'h002518: r = 8'hD9;
        21'h00250C: r = 8'hDA;
        21'h002588: r = 8'hDB;
        21'h002584: r = 8'hDC;
        21'h00258C: r = 8'hDD;
        21'h002590: r = 8'hDE;
        21'h002580: r = 8'hDF;
        21'h002022: r = 8'h07;
        21'h00263A: r = 8'h01;
        21'h002665: r = 8'h03;
        21'h002666: r = 8'h04;
        21'h00263C: r = 8'h0F;
        21'h0025BA: r = 8'h10;
        21'h0025C4: r = 8'h11;
        21'h002191: r = 8'h18;
        21'h002193: r = 8'h19;
        21'h002192: r = 8'h1A;
        21'h002190: r = 8'h1B;
        21'h0000AB: r = 8'h3C;
        21'h0000BB: r = 8'h3E;
        21'h002014: r = 8'hC4;
        21'h002013: r = 8'hC4;
        21'h00201C: r = 8'h22;
        21'h00201D: r = 8'h22;
        default:    r = Unmapped;
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/u8cp_front.sv
// Front end: accepts UTF-8 bytes, tracks the pending sequence and classifies
// each byte into queue entries. Depends on u8cp_pkg.
module u8cp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            text_byte_i,
  input  logic                  full_i,
  output logic                  push_o,
  output u8cp_pkg::evt_entry_t  entry_o
);

  logic [u8cp_pkg::CpW-1:0] cp_q, cp_d;
  logic [1:0]               rem_q, rem_d;
  logic                     accept;
  logic                     pend;
  logic                     is_cont;
  logic [u8cp_pkg::CpW-1:0] cp_shift;
  logic [1:0]               rem_dec;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pend       = (rem_q != 2'd0);
  assign is_cont    = (text_byte_i[7:6] == 2'b10);
  assign cp_shift   = {cp_q[u8cp_pkg::CpW-7:0], text_byte_i[5:0]};
  assign rem_dec    = rem_q - 2'd1;

  always_comb begin
    cp_d            = cp_q;
    rem_d           = rem_q;
    entry_o.a_valid = 1'b0;
    entry_o.a_cp    = cp_q;
    entry_o.b_kind  = u8cp_pkg::EvNone;
    entry_o.b_byte  = text_byte_i;
    if (pend && is_cont) begin
      // Continuation byte extends the pending sequence.
      rem_d = rem_dec;
      if (rem_dec == 2'd0) begin
        entry_o.a_valid = 1'b1;
        entry_o.a_cp    = cp_shift;
        cp_d            = '0;
      end else begin
        cp_d = cp_shift;
      end
    end else begin
      // A pending sequence cut short is flushed ahead of this byte.
      entry_o.a_valid = pend;
      cp_d            = '0;
      rem_d           = 2'd0;
      if (text_byte_i == 8'h00) begin
        entry_o.b_kind = u8cp_pkg::EvEnd;
      end else if (!text_byte_i[7]) begin
        entry_o.b_kind = u8cp_pkg::EvChar;
      end else if (text_byte_i[7:5] == 3'b110) begin
        cp_d  = {{(u8cp_pkg::CpW-5){1'b0}}, text_byte_i[4:0]};
        rem_d = 2'd1;
      end else if (text_byte_i[7:4] == 4'b1110) begin
        cp_d  = {{(u8cp_pkg::CpW-4){1'b0}}, text_byte_i[3:0]};
        rem_d = 2'd2;
      end else if (text_byte_i[7:3] == 5'b11110) begin
        cp_d  = {{(u8cp_pkg::CpW-3){1'b0}}, text_byte_i[2:0]};
        rem_d = 2'd3;
      end else begin
        // Stray continuation byte or 0xF8..0xFF stands for itself.
        entry_o.b_kind = u8cp_pkg::EvChar;
      end
    end
  end

  assign push_o = accept && (entry_o.a_valid || (entry_o.b_kind != u8cp_pkg::EvNone));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q  <= '0;
      rem_q <= 2'd0;
    end else if (accept) begin
      cp_q  <= cp_d;
      rem_q <= rem_d;
    end
  end

endmodule

>>> rtl/u8cp_fifo.sv
// Small queue of classified entries between the front end and the back end.
// Depends on u8cp_pkg; the depth must be a power of two.
module u8cp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u8cp_pkg::evt_entry_t  entry_i,
  output logic                  full_o,
  output logic                  head_valid_o,
  output u8cp_pkg::evt_entry_t  head_o,
  input  logic                  pop_i
);

  u8cp_pkg::evt_entry_t          mem_q [u8cp_pkg::FifoDepth];
  logic [u8cp_pkg::PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [u8cp_pkg::FillW-1:0]    fill_q;
  logic                          do_push, do_pop;

  assign full_o       = (fill_q == u8cp_pkg::FillW'(u8cp_pkg::FifoDepth));
  assign head_valid_o = (fill_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + u8cp_pkg::PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + u8cp_pkg::PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + u8cp_pkg::FillW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - u8cp_pkg::FillW'(1);
      end
    end
  end

endmodule

>>> rtl/u8cp_back.sv
// Back end: counts characters against the limit, maps code points to CP866
// and drives the output register. Depends on u8cp_pkg.
module u8cp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [u8cp_pkg::MaxW-1:0]   cfg_wdata_i,
  input  logic                        head_valid_i,
  input  u8cp_pkg::evt_entry_t        head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [7:0]                  cp866_byte_o,
  output logic [u8cp_pkg::CountW-1:0] char_count_o,
  output logic                        last_of_run_o
);

  logic [u8cp_pkg::MaxW-1:0]   max_q;
  logic [u8cp_pkg::CountW-1:0] cnt_q, cnt_d;
  u8cp_pkg::phase_e            phase_q, phase_d;

  logic                        out_valid_q;
  logic                        kind_q;
  logic [7:0]                  byte_q;
  logic [u8cp_pkg::CountW-1:0] res_cnt_q;
  logic                        last_q;

  logic                        step, do_a, load;
  logic                        kept_a, b_has_res;
  logic [u8cp_pkg::CountW-1:0] cnt_inc, cnt_after_a, res_cnt;
  logic [u8cp_pkg::CpW-1:0]    map_in;
  logic [7:0]                  mapped, res_byte;
  logic                        res_kind, res_last;

  function automatic logic under_limit(input logic [u8cp_pkg::CountW-1:0] c,
                                       input logic [u8cp_pkg::MaxW-1:0]   m);
    return (c < u8cp_pkg::CountW'(m)) && (c != '1);
  endfunction

  assign step        = head_valid_i && (!out_valid_q || out_ready_i);
  assign do_a        = (phase_q == u8cp_pkg::PhA) && head_i.a_valid;
  assign kept_a      = under_limit(cnt_q, max_q);
  assign cnt_inc     = cnt_q + u8cp_pkg::CountW'(1);
  assign cnt_after_a = kept_a ? cnt_inc : cnt_q;
  assign b_has_res   = (head_i.b_kind == u8cp_pkg::EvEnd) ||
                       ((head_i.b_kind == u8cp_pkg::EvChar) &&
                        under_limit(cnt_after_a, max_q));
  assign map_in      = do_a ? head_i.a_cp
                            : {{(u8cp_pkg::CpW-8){1'b0}}, head_i.b_byte};
  assign mapped      = u8cp_pkg::map_code(map_in);

  always_comb begin
    pop_o    = 1'b0;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    load     = 1'b0;
    res_kind = u8cp_pkg::ResChar;
    res_byte = mapped;
    res_cnt  = cnt_inc;
    res_last = 1'b1;
    if (step) begin
      if (do_a) begin
        load     = kept_a;
        cnt_d    = cnt_after_a;
        res_last = !b_has_res;
        if (head_i.b_kind == u8cp_pkg::EvNone) begin
          pop_o = 1'b1;
        end else begin
          phase_d = u8cp_pkg::PhB;
        end
      end else begin
        pop_o   = 1'b1;
        phase_d = u8cp_pkg::PhA;
        case (head_i.b_kind)
          u8cp_pkg::EvChar: begin
            load = kept_a;
            if (kept_a) begin
              cnt_d = cnt_inc;
            end
          end
          u8cp_pkg::EvEnd: begin
            load     = 1'b1;
            res_kind = u8cp_pkg::ResEnd;
            res_byte = 8'h00;
            res_cnt  = cnt_q;
            cnt_d    = '0;
          end
          default: begin
            load = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '1;
      cnt_q       <= '0;
      phase_q     <= u8cp_pkg::PhA;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= res_kind;
      byte_q    <= res_byte;
      res_cnt_q <= res_cnt;
      last_q    <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign cp866_byte_o  = byte_q;
  assign char_count_o  = res_cnt_q;
  assign last_of_run_o = last_q;

endmodule

>>> rtl/utf8_to_cp866_transcoder_unit.sv
// UTF-8 to CP866 transcoder, top level: one UTF-8 byte in per transaction,
// CP866 characters and end-of-string results out; one transaction per cycle
// on both sides while the output is ready and no byte cuts a sequence short.
// A byte that cuts a pending sequence short and also stands for a character
// or ends the string yields up to two results, which the back end handles in
// turn; the two-entry queue then fills, so each such byte stalls the input
// even with the output always ready. The first result of a byte passes
// through the queue and the output register. The front end keeps the partial
// code point and the count of continuation bytes still expected, and files at
// most one queue entry per byte. The back end owns the character counter and
// the max_chars limit: characters past the limit are decoded but dropped, and
// the end-of-string result (from a zero byte) always goes out with the total
// count and clears the counter. Bytes that only extend a sequence, or whose
// character is dropped, give no result; last_of_run_o marks the final result
// of each byte. The user must write max_chars through cfg_we_i / cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// Depends on u8cp_pkg, u8cp_front, u8cp_fifo, u8cp_back and the defines header.
`include "utf8_to_cp866_transcoder_unit_defines.svh"

module utf8_to_cp866_transcoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [u8cp_pkg::MaxW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  text_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [7:0]                  cp866_byte_o,
  output logic [u8cp_pkg::CountW-1:0] char_count_o,
  output logic                        last_of_run_o
);

  logic                 push;
  u8cp_pkg::evt_entry_t entry;
  logic                 full;
  logic                 head_valid;
  u8cp_pkg::evt_entry_t head;
  logic                 pop;

  // Front end: sequence tracking and classification.
  u8cp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry)
  );

  // Queue that decouples the two ends.
  u8cp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back end: limit, mapping and output register.
  u8cp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .cp866_byte_o  (cp866_byte_o),
    .char_count_o  (char_count_o),
    .last_of_run_o (last_of_run_o)
  );

  // An end-of-string result carries a zero byte and closes its byte's run.
  `U8CP_ASSERT_SAME(a_end_shape, out_valid_o && (result_kind_o == u8cp_pkg::ResEnd), (cp866_byte_o == 8'h00) && last_of_run_o)
  // A character result always counts at least itself.
  `U8CP_ASSERT_SAME(a_char_count, out_valid_o && (result_kind_o == u8cp_pkg::ResChar), char_count_o != '0)
  // Back pressure on the input only comes from a queue with work in it.
  `U8CP_ASSERT_SAME(a_stall_has_work, !in_ready_o, head_valid)
  // A pop without a push leaves the queue with room.
  `U8CP_ASSERT_NEXT(a_pop_frees, pop && !push, in_ready_o)

endmodule
